// ===== hw/rtl/mbe_pkg.sv =====
package mbe_pkg;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_X_MIN    = 3'd0,
        REG_Y_MIN    = 3'd1,
        REG_X_STEP   = 3'd2,
        REG_Y_STEP   = 3'd3,
        REG_ITER_LIM = 3'd4,
        REG_RADIUS   = 3'd5
    } t_reg_idx;

    // field widths
    localparam int unsigned PIX_W   = 10;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned STEP_W  = 31;
    localparam int unsigned ITER_W  = 16;
    localparam int unsigned RAD_W   = 4;
    localparam int unsigned PROD_W  = 2 * COORD_W;

    // reset values
    localparam logic signed [COORD_W-1:0] X_MIN_RST    = -32'sd54358179;
    localparam logic signed [COORD_W-1:0] Y_MIN_RST    = -32'sd20803502;
    localparam logic        [STEP_W-1:0]  X_STEP_RST   = 31'd40634;
    localparam logic        [STEP_W-1:0]  Y_STEP_RST   = 31'd40634;
    localparam logic        [ITER_W-1:0]  ITER_LIM_RST = 16'd100;
    localparam logic        [RAD_W-1:0]   RADIUS_RST   = 4'd2;

    // iterations applied after the limit is reached
    localparam int unsigned EXTRA_ITERS = 4;
    localparam int unsigned EXTRA_W     = $clog2(EXTRA_ITERS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } t_state;

    // clamp a 64-bit signed value to the 32-bit range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = {{(PROD_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
        lo = {{(PROD_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
        if (v > hi) begin
            return hi[COORD_W-1:0];
        end else if (v < lo) begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/mbe_pix_if.sv =====
interface mbe_pix_if;
    import mbe_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

// ===== hw/rtl/mbe_res_if.sv =====
interface mbe_res_if;
    import mbe_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [ITER_W-1:0]         iter_count;
    logic signed [COORD_W-1:0] z_real;
    logic signed [COORD_W-1:0] z_imag;
    logic                      inside_res;

    modport source (output valid, output iter_count, output z_real, output z_imag,
                    output inside_res, input ready);
    modport sink   (input valid, input iter_count, input z_real, input z_imag,
                    input inside_res, output ready);
endinterface

// ===== hw/rtl/mbe_cfg_if.sv =====
interface mbe_cfg_if;
    import mbe_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== hw/rtl/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time engine, signed fixed point (Q8.24 by default).
// i_pix : one word per pixel (column, row). Taken only while the engine is idle.
// o_res : one word per pixel: iteration count, final z and the inside flag.
// i_cfg : register writes (addr = register index, data = value); always ready,
//         only to be used while no pixel is in flight. Unknown indexes are dropped.
// Sequence: an accept state, a state that maps the pixel to c, then per escape
// test a multiply state on the squaring unit and an update state that tests
// |z|^2 and forms z*z + c. An inside point runs four extra iterations after the
// limit is reached. One pixel is worked on at a time: a new pixel is taken only
// once the last one has left its final state.
// The result sits in an output register, so the next pixel is taken while a
// finished word still waits; if the receiver stalls longer than a whole pixel,
// the engine holds in its final state until the register frees.
// Reset (synchronous, active low) returns the sequencer to idle, drops any
// pending result and loads the default view registers.
module mandelbrot_escape_time #(
    parameter int unsigned FRAC_BITS = 24
) (
    input logic      i_clk,
    input logic      i_rst_n,
    mbe_pix_if.sink   i_pix,
    mbe_res_if.source o_res,
    mbe_cfg_if.sink   i_cfg
);
    import mbe_pkg::*;

    localparam int unsigned MAP_W = PIX_W + STEP_W;

    // view registers
    logic signed [COORD_W-1:0] r_x_min;
    logic signed [COORD_W-1:0] r_y_min;
    logic [STEP_W-1:0]         r_x_step;
    logic [STEP_W-1:0]         r_y_step;
    logic [ITER_W-1:0]         r_iter_lim;
    logic [RAD_W-1:0]          r_radius;

    // sequencer
    t_state r_state, n_state;

    // working set for one pixel
    logic [PIX_W-1:0]          r_col;
    logic [PIX_W-1:0]          r_row;
    logic signed [COORD_W-1:0] r_cr, r_ci;
    logic signed [COORD_W-1:0] r_zr, r_zi;
    logic [PROD_W-1:0]         r_limit;
    logic signed [PROD_W-1:0]  r_xx, r_yy, r_xy;
    logic [ITER_W-1:0]         r_count;
    logic                      r_extra;
    logic [EXTRA_W-1:0]        r_xcnt;

    // result register
    logic                      r_out_valid;
    logic [ITER_W-1:0]         r_out_count;
    logic signed [COORD_W-1:0] r_out_zr, r_out_zi;
    logic                      r_out_inside;

    // combinational datapath
    logic [MAP_W-1:0]          col_off, row_off;
    logic signed [COORD_W-1:0] map_cr, map_ci;
    logic [PROD_W-1:0]         map_limit;
    logic [2*RAD_W-1:0]        rad_sq;
    logic [PROD_W-1:0]         mag;
    logic signed [PROD_W-1:0]  re_sum, im_sum;
    logic signed [COORD_W-1:0] new_zr, new_zi;
    logic                      escape;
    logic                      at_limit;
    logic                      last_extra;
    logic                      load_out;

    // control
    logic pix_take;
    logic do_map, do_mul, do_step, go_extra;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = (r_state == ST_IDLE);
    assign pix_take    = i_pix.valid && (r_state == ST_IDLE);

    // pixel to c, saturated
    assign col_off   = MAP_W'(r_col) * MAP_W'(r_x_step);
    assign row_off   = MAP_W'(r_row) * MAP_W'(r_y_step);
    assign map_cr    = sat32(PROD_W'(r_x_min) + $signed({{(PROD_W-MAP_W){1'b0}}, col_off}));
    assign map_ci    = sat32(PROD_W'(r_y_min) + $signed({{(PROD_W-MAP_W){1'b0}}, row_off}));
    assign rad_sq    = (2*RAD_W)'(r_radius) * (2*RAD_W)'(r_radius);
    assign map_limit = PROD_W'(rad_sq) << (2 * FRAC_BITS);

    // |z|^2 and z*z + c from the registered products
    assign mag    = r_xx + r_yy;
    assign re_sum = ((r_xx - r_yy) >>> FRAC_BITS) + PROD_W'(r_cr);
    assign im_sum = (r_xy >>> (FRAC_BITS - 1)) + PROD_W'(r_ci);
    assign new_zr = sat32(re_sum);
    assign new_zi = sat32(im_sum);

    assign escape     = !(mag < r_limit) || (r_count >= r_iter_lim);
    assign at_limit   = (r_count == r_iter_lim);
    assign last_extra = (r_xcnt == EXTRA_W'(EXTRA_ITERS - 1));
    assign load_out   = (r_state == ST_DONE) && (!r_out_valid || o_res.ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_pix.valid) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP: n_state = ST_MUL;
            ST_MUL: n_state = ST_UPD;
            ST_UPD: begin
                if (r_extra) begin
                    n_state = last_extra ? ST_DONE : ST_MUL;
                end else if (escape && !at_limit) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        do_map   = 1'b0;
        do_mul   = 1'b0;
        do_step  = 1'b0;
        go_extra = 1'b0;
        unique case (r_state)
            ST_MAP: do_map = 1'b1;
            ST_MUL: do_mul = 1'b1;
            ST_UPD: begin
                if (r_extra || !escape) begin
                    do_step = 1'b1;
                end else if (at_limit) begin
                    go_extra = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_x_min     <= X_MIN_RST;
            r_y_min     <= Y_MIN_RST;
            r_x_step    <= X_STEP_RST;
            r_y_step    <= Y_STEP_RST;
            r_iter_lim  <= ITER_LIM_RST;
            r_radius    <= RADIUS_RST;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                case (i_cfg.addr)
                    REG_X_MIN:    r_x_min    <= i_cfg.data;
                    REG_Y_MIN:    r_y_min    <= i_cfg.data;
                    REG_X_STEP:   r_x_step   <= i_cfg.data[STEP_W-1:0];
                    REG_Y_STEP:   r_y_step   <= i_cfg.data[STEP_W-1:0];
                    REG_ITER_LIM: r_iter_lim <= i_cfg.data[ITER_W-1:0];
                    REG_RADIUS:   r_radius   <= i_cfg.data[RAD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (pix_take) begin
            r_col <= i_pix.pixel_col;
            r_row <= i_pix.pixel_row;
        end
        if (do_map) begin
            r_cr    <= map_cr;
            r_ci    <= map_ci;
            r_zr    <= map_cr;
            r_zi    <= map_ci;
            r_limit <= map_limit;
            r_count <= '0;
            r_extra <= 1'b0;
            r_xcnt  <= '0;
        end
        // squaring unit: three independent 32x32 products
        if (do_mul) begin
            r_xx <= PROD_W'(r_zr) * PROD_W'(r_zr);
            r_yy <= PROD_W'(r_zi) * PROD_W'(r_zi);
            r_xy <= PROD_W'(r_zr) * PROD_W'(r_zi);
        end
        if (do_step) begin
            r_zr <= new_zr;
            r_zi <= new_zi;
            if (r_extra) begin
                r_xcnt <= r_xcnt + 1'b1;
            end else begin
                r_count <= r_count + 1'b1;
            end
        end
        if (go_extra) begin
            r_extra <= 1'b1;
        end
        if (load_out) begin
            r_out_count  <= r_count;
            r_out_zr     <= r_zr;
            r_out_zi     <= r_zi;
            r_out_inside <= r_extra;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.iter_count = r_out_count;
    assign o_res.z_real     = r_out_zr;
    assign o_res.z_imag     = r_out_zi;
    assign o_res.inside_res = r_out_inside;

endmodule

// ===== verif/mbe_escape_scoreboard.sv =====
`timescale 1ns / 1ps

// Watches the pixel, result and register channels of the escape-time engine.
// Keeps its own copy of the view registers, predicts each pixel's word and
// compares the words that come back, in order.
module mbe_escape_scoreboard #(
    parameter int unsigned FRAC_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbe_pix_if          i_pix,
    mbe_res_if          i_res,
    mbe_cfg_if          i_cfg,
    output int unsigned o_fail_cnt,
    output int unsigned o_pending,
    output int unsigned o_word_cnt,
    output int unsigned o_inside_cnt
);
    import mbe_pkg::*;

    typedef struct packed {
        logic [ITER_W-1:0]         iter_count;
        logic signed [COORD_W-1:0] z_real;
        logic signed [COORD_W-1:0] z_imag;
        logic                      inside_res;
    } t_escape_word;

    localparam longint COORD_HI = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_LO = -(longint'(1) <<< (COORD_W - 1));

    logic signed [COORD_W-1:0] view_x_min;
    logic signed [COORD_W-1:0] view_y_min;
    logic [STEP_W-1:0]         view_x_step;
    logic [STEP_W-1:0]         view_y_step;
    logic [ITER_W-1:0]         view_iter_lim;
    logic [RAD_W-1:0]          view_radius;

    t_escape_word pending_escapes[$];
    t_escape_word got_word;
    t_escape_word want_word;

    function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
        if (v > COORD_HI) begin
            v = COORD_HI;
        end else if (v < COORD_LO) begin
            v = COORD_LO;
        end
        return v[COORD_W-1:0];
    endfunction

    // exact |z|^2, no rounding
    function automatic longint unsigned magnitude_sq(input logic signed [COORD_W-1:0] zr,
                                                     input logic signed [COORD_W-1:0] zi);
        longint x;
        longint y;
        x = zr;
        y = zi;
        return $unsigned(x * x) + $unsigned(y * y);
    endfunction

    // z <- z*z + c, products floored, sums clamped
    function automatic void square_plus_c(inout logic signed [COORD_W-1:0] zr,
                                          inout logic signed [COORD_W-1:0] zi,
                                          input logic signed [COORD_W-1:0] cr,
                                          input logic signed [COORD_W-1:0] ci);
        longint x;
        longint y;
        x  = zr;
        y  = zi;
        zr = clamp_coord(((x * x - y * y) >>> FRAC_BITS) + longint'(cr));
        zi = clamp_coord(((x * y) >>> (FRAC_BITS - 1)) + longint'(ci));
    endfunction

    function automatic t_escape_word predict_escape(input logic [PIX_W-1:0] col,
                                                    input logic [PIX_W-1:0] row);
        logic signed [COORD_W-1:0] cr;
        logic signed [COORD_W-1:0] ci;
        logic signed [COORD_W-1:0] zr;
        logic signed [COORD_W-1:0] zi;
        longint unsigned           r2;
        longint unsigned           bound;
        int unsigned               n;
        t_escape_word              w;
        cr    = clamp_coord(longint'(view_x_min) + longint'(col) * longint'(view_x_step));
        ci    = clamp_coord(longint'(view_y_min) + longint'(row) * longint'(view_y_step));
        r2    = view_radius;
        bound = (r2 * r2) << (2 * FRAC_BITS);
        zr    = cr;
        zi    = ci;
        n     = 0;
        while (magnitude_sq(zr, zi) < bound && n < view_iter_lim) begin
            square_plus_c(zr, zi, cr, ci);
            n++;
        end
        w.inside_res = (n == view_iter_lim);
        if (w.inside_res) begin
            repeat (EXTRA_ITERS) square_plus_c(zr, zi, cr, ci);
        end
        w.iter_count = n[ITER_W-1:0];
        w.z_real     = zr;
        w.z_imag     = zi;
        return w;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            view_x_min    = X_MIN_RST;
            view_y_min    = Y_MIN_RST;
            view_x_step   = X_STEP_RST;
            view_y_step   = Y_STEP_RST;
            view_iter_lim = ITER_LIM_RST;
            view_radius   = RADIUS_RST;
            pending_escapes.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got_word.iter_count = i_res.iter_count;
                got_word.z_real     = i_res.z_real;
                got_word.z_imag     = i_res.z_imag;
                got_word.inside_res = i_res.inside_res;
                if (pending_escapes.size() == 0) begin
                    $error("result word with no pixel outstanding: iter_count %0d",
                           got_word.iter_count);
                    o_fail_cnt++;
                end else begin
                    want_word = pending_escapes.pop_front();
                    if (got_word.iter_count !== want_word.iter_count) begin
                        $error("iter_count: expected %0d, got %0d",
                               want_word.iter_count, got_word.iter_count);
                        o_fail_cnt++;
                    end
                    if (got_word.z_real !== want_word.z_real) begin
                        $error("z_real: expected %0d, got %0d",
                               $signed(want_word.z_real), $signed(got_word.z_real));
                        o_fail_cnt++;
                    end
                    if (got_word.z_imag !== want_word.z_imag) begin
                        $error("z_imag: expected %0d, got %0d",
                               $signed(want_word.z_imag), $signed(got_word.z_imag));
                        o_fail_cnt++;
                    end
                    if (got_word.inside_res !== want_word.inside_res) begin
                        $error("inside_res: expected %0d, got %0d",
                               want_word.inside_res, got_word.inside_res);
                        o_fail_cnt++;
                    end
                    o_word_cnt++;
                    if (want_word.inside_res) begin
                        o_inside_cnt++;
                    end
                end
            end
            // predict with the view as it stands when the pixel is taken
            if (i_pix.valid && i_pix.ready) begin
                pending_escapes.push_back(predict_escape(i_pix.pixel_col, i_pix.pixel_row));
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.addr)
                    REG_X_MIN:    view_x_min    = i_cfg.data;
                    REG_Y_MIN:    view_y_min    = i_cfg.data;
                    REG_X_STEP:   view_x_step   = i_cfg.data[STEP_W-1:0];
                    REG_Y_STEP:   view_y_step   = i_cfg.data[STEP_W-1:0];
                    REG_ITER_LIM: view_iter_lim = i_cfg.data[ITER_W-1:0];
                    REG_RADIUS:   view_radius   = i_cfg.data[RAD_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = pending_escapes.size();
    end

endmodule

// ===== verif/mandelbrot_escape_time_tb.sv =====
`timescale 1ns / 1ps

module mandelbrot_escape_time_tb;
    import mbe_pkg::*;

    localparam int unsigned FRAC_BITS    = 24;
    localparam int unsigned CLK_PERIOD   = 12;
    localparam int unsigned RANDOM_ITEMS = 1450;
    // slowest honest run: ~1450 pixels at up to 255 iterations, plus stalls, and one
    // inside pixel at an iteration limit of 65535
    localparam int unsigned LIMIT_CYCLES = 4_000_000;
    localparam int unsigned TAIL_CYCLES  = 40;
    localparam int unsigned PIX_MAX      = (1 << PIX_W) - 1;
    localparam int          ONE_Q        = 1 << FRAC_BITS;    // 1.0 in Q8.24

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

    logic i_clk;
    logic i_rst_n;

    mbe_pix_if pix_ch ();
    mbe_res_if res_ch ();
    mbe_cfg_if cfg_ch ();

    int unsigned fail_cnt;
    int unsigned words_pending;
    int unsigned words_checked;
    int unsigned inside_cnt;

    int unsigned cycle_cnt = 0;
    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;
    int unsigned view_cnt;
    int unsigned sent;

    mandelbrot_escape_time #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_ch),
        .o_res  (res_ch),
        .i_cfg  (cfg_ch)
    );

    mbe_escape_scoreboard #(
        .FRAC_BITS(FRAC_BITS)
    ) u_escape_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_ch),
        .i_res       (res_ch),
        .i_cfg       (cfg_ch),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (words_pending),
        .o_word_cnt  (words_checked),
        .o_inside_cnt(inside_cnt)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: ready drawn fresh every cycle
    always @(negedge i_clk) begin
        res_ch.ready = ($urandom_range(99) >= rcv_idle_pct);
    end

    task automatic set_idling(input int unsigned snd, input int unsigned rcv);
        snd_idle_pct = snd;
        rcv_idle_pct = rcv;
    endtask

    // one pixel word; valid stays high into the next call unless it idles
    task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            pix_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid     = 1'b1;
        pix_ch.pixel_col = col;
        pix_ch.pixel_row = row;
        do @(posedge i_clk); while (!pix_ch.ready);
    endtask

    // sender holds off until every predicted word has come back
    task automatic wait_for_results();
        @(negedge i_clk);
        pix_ch.valid = 1'b0;
        while (words_pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.addr  = idx;
        cfg_ch.data  = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // pick a fresh view; junk is put above the width of the step, limit and radius registers
    task automatic new_view();
        int unsigned           kind;
        int unsigned           pick;
        longint                cx;
        longint                cy;
        longint                xm;
        longint                ym;
        logic [31:0]           xs;
        logic [31:0]           ys;
        logic [ITER_W-1:0]     iters;
        logic [RAD_W-1:0]      rad;
        logic [31:0]           junk;
        kind = $urandom_range(0, 9);
        rad  = ($urandom_range(0, 9) < 6) ? RAD_W'(2) : RAD_W'($urandom_range(0, 15));
        if (kind < 6) begin
            // ordinary window around the set, spans from very deep zoom to whole set
            xs = $urandom_range(64, 48000);
            ys = $urandom_range(1) ? xs : $urandom_range(64, 48000);
            cx = longint'($urandom_range(0, 3 * ONE_Q)) - 2 * ONE_Q;
            cy = longint'($urandom_range(0, 2 * ONE_Q)) - ONE_Q;
            xm = cx - 512 * longint'(xs);
            ym = cy - 512 * longint'(ys);
        end else if (kind < 8) begin
            // big radius with big c: z runs into the clamps
            rad = RAD_W'($urandom_range(8, 15));
            xs  = $urandom_range(0, ONE_Q / 16);
            ys  = $urandom_range(0, ONE_Q / 16);
            xm  = longint'($urandom_range(0, 32 * ONE_Q)) - 16 * ONE_Q;
            ym  = longint'($urandom_range(0, 32 * ONE_Q)) - 16 * ONE_Q;
        end else begin
            // raw noise over the whole register space
            xs = $urandom;
            ys = $urandom;
            xm = longint'($urandom);
            ym = longint'($urandom);
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            iters = '0;
        end else if (pick < 4) begin
            iters = ITER_W'($urandom_range(129, 255));
        end else begin
            iters = ITER_W'($urandom_range(1, 128));
        end
        junk = $urandom;
        write_reg(REG_X_MIN, xm[31:0]);
        write_reg(REG_Y_MIN, ym[31:0]);
        write_reg(REG_X_STEP, {junk[31], xs[STEP_W-1:0]});
        write_reg(REG_Y_STEP, {junk[30], ys[STEP_W-1:0]});
        write_reg(REG_ITER_LIM, {junk[15:0], iters});
        write_reg(REG_RADIUS, {junk[27:0], rad});
    endtask

    initial begin
        i_rst_n          = 1'b0;
        pix_ch.valid     = 1'b0;
        pix_ch.pixel_col = '0;
        pix_ch.pixel_row = '0;
        res_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.addr      = '0;
        cfg_ch.data      = '0;
        view_cnt         = 0;
        sent             = 0;
        set_idling(34, 64);

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed ---

        // default view after reset: corners, a point just inside the period-2 bulb and one further point
        send_pixel(0, 0);
        send_pixel(PIX_MAX, PIX_MAX);
        send_pixel(PIX_MAX, 512);
        send_pixel(700, 300);
        wait_for_results();

        // writes to indexes past the list leave the view alone
        write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_7, 32'h0000_0000);
        send_pixel(PIX_MAX, 512);
        wait_for_results();

        // extreme registers: c reaches both ends of the range and clamps high, escapes at once
        write_reg(REG_X_MIN, 32'h8000_0000);
        write_reg(REG_Y_MIN, 32'h7FFF_FFFF);
        write_reg(REG_X_STEP, 32'hFFFF_FFFF);
        write_reg(REG_Y_STEP, 32'h8000_0000);
        write_reg(REG_ITER_LIM, 32'h0001_FFFF);
        write_reg(REG_RADIUS, 32'hFFFF_FFFF);
        send_pixel(0, 0);
        send_pixel(PIX_MAX, PIX_MAX);
        send_pixel(1, 5);
        wait_for_results();

        // zero limit with zero radius: inside at count 0, extra passes still run
        write_reg(REG_X_MIN, 32'h0);
        write_reg(REG_Y_MIN, 32'h0);
        write_reg(REG_X_STEP, ONE_Q / 16);
        write_reg(REG_Y_STEP, ONE_Q / 16);
        write_reg(REG_ITER_LIM, 32'h0);
        write_reg(REG_RADIUS, 32'h0);
        send_pixel(0, 0);
        send_pixel(PIX_MAX, PIX_MAX);
        send_pixel(37, 200);
        wait_for_results();

        // zero radius alone: count 0, not inside, z left at c
        write_reg(REG_ITER_LIM, 32'd7);
        send_pixel(5, 9);
        wait_for_results();

        // widest radius with c near the edge of it: the first square clamps
        write_reg(REG_X_MIN, 14 * ONE_Q);
        write_reg(REG_X_STEP, 32'h0);
        write_reg(REG_Y_STEP, ONE_Q);
        write_reg(REG_ITER_LIM, 32'h0000_FFFF);
        write_reg(REG_RADIUS, 32'd15);
        send_pixel(0, 0);
        send_pixel(PIX_MAX, 3);
        wait_for_results();

        // c = 0 at the largest limit: the one long pixel of the run
        write_reg(REG_X_MIN, 32'h0);
        write_reg(REG_Y_STEP, 32'h0);
        send_pixel(0, 0);
        wait_for_results();

        // --- random views ---
        while (sent < RANDOM_ITEMS) begin
            if (sent < RANDOM_ITEMS / 3) begin
                set_idling(34, 64);
            end else if (sent < 2 * RANDOM_ITEMS / 3) begin
                set_idling(64, 34);
            end else begin
                set_idling(0, 0);
            end
            wait_for_results();
            new_view();
            view_cnt++;
            repeat ($urandom_range(20, 60)) begin
                send_pixel(PIX_W'($urandom_range(0, PIX_MAX)),
                           PIX_W'($urandom_range(0, PIX_MAX)));
                sent++;
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d words (%0d inside the set) across %0d random views",
                 words_checked, inside_cnt, view_cnt);
        $display("plus directed clamp, zero-limit, zero-radius and full-limit cases");
        if (fail_cnt == 0 && words_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_pix_if.sv
hw/rtl/mbe_res_if.sv
hw/rtl/mbe_cfg_if.sv
hw/rtl/mandelbrot_escape_time.sv
verif/mbe_escape_scoreboard.sv
verif/mandelbrot_escape_time_tb.sv
